// ===== sv/qsd_pkg.sv =====
// Shared types and constants for the quad-SPI sample deserializer.
// Depends on nothing; imported by qsd_core, the top level and the testbench.
`timescale 1ns / 1ps

package qsd_pkg;

  localparam int NIBBLES_PER_WORD = 16;
  localparam int COUNT_BITS       = 20;
  localparam int NIB_W            = 4;
  localparam int WORD_W           = NIBBLES_PER_WORD * NIB_W;
  localparam int SLOT_W           = $clog2(NIBBLES_PER_WORD);
  localparam int WNIB_W           = $clog2(NIBBLES_PER_WORD + 1);
  localparam int SAMPLE_W         = 8;
  localparam int MODE_W           = 2;

  // Bit positions inside one sample.
  localparam int CLK_POS = 5;
  localparam int SEL_POS = 4;

  // Edge mode codes. Code three is treated like MODE_FIRST.
  localparam logic [MODE_W-1:0] MODE_AFTER  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEFORE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0]     packed_word;
    logic [WNIB_W-1:0]     word_nibbles;
    logic                  frame_done;
    logic [COUNT_BITS-1:0] frame_nibbles;
  } qsd_result_t;

endpackage

// ===== sv/qsd_core.sv =====
// Frame tracking, nibble capture and word packing for one sample per step.
// Depends on qsd_pkg for widths, mode codes and the result struct.
`timescale 1ns / 1ps

module qsd_core import qsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [SAMPLE_W-1:0] sample_byte_i,
  input  logic                capture_end_i,
  input  logic [MODE_W-1:0]   edge_mode_i,
  output logic                res_valid_o,
  output qsd_result_t         res_o
);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_FRAME,
    PH_IDLE
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [5:0]            prev_q, prev_d;
  logic                  pif_q, pif_d;
  logic [WORD_W-1:0]     acc_q, acc_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [COUNT_BITS-1:0] total_q, total_d;

  logic [5:0]        s;
  logic              sel, fall, before_mode, first_cap;
  logic              cap, frame_ends, word_ready;
  logic [NIB_W-1:0]  cap_nib;
  logic [WORD_W-1:0] acc_cap;

  assign s           = sample_byte_i[5:0];
  assign sel         = s[SEL_POS];
  assign fall        = prev_q[CLK_POS] & ~s[CLK_POS];
  assign before_mode = (edge_mode_i != MODE_AFTER);
  // MODE_FIRST and the unused code three both have the upper bit set.
  assign first_cap   = edge_mode_i[1];

  always_comb begin
    phase_d    = phase_q;
    pif_d      = pif_q;
    cap        = 1'b0;
    cap_nib    = s[NIB_W-1:0];
    frame_ends = 1'b0;

    case (phase_q)
      PH_SEARCH: begin
        if (sel) begin
          phase_d = PH_FRAME;
          if (first_cap || (!before_mode && fall)) begin
            cap = 1'b1;
          end
          pif_d = !first_cap;
          frame_ends = capture_end_i;
        end
      end
      PH_FRAME: begin
        // In the pre-edge modes the nibble comes from the sample before the edge.
        if (before_mode && pif_q && fall) begin
          cap     = 1'b1;
          cap_nib = prev_q[NIB_W-1:0];
        end
        if (sel) begin
          if (!before_mode && fall) begin
            cap = 1'b1;
          end
          pif_d = 1'b1;
          frame_ends = capture_end_i;
        end else begin
          frame_ends = 1'b1;
        end
      end
      PH_IDLE: begin
      end
      default: begin
        phase_d = PH_SEARCH;
      end
    endcase

    acc_cap = acc_q;
    acc_cap[int'(slot_q) * NIB_W +: NIB_W] = acc_q[int'(slot_q) * NIB_W +: NIB_W] | cap_nib;

    acc_d      = acc_q;
    slot_d     = slot_q;
    total_d    = total_q;
    word_ready = 1'b0;
    if (cap) begin
      if (total_q != '1) begin
        total_d = total_q + 1'b1;
      end
      if (slot_q == SLOT_W'(NIBBLES_PER_WORD - 1)) begin
        word_ready = 1'b1;
        acc_d      = '0;
        slot_d     = '0;
      end else begin
        acc_d  = acc_cap;
        slot_d = slot_q + 1'b1;
      end
    end

    res_o.frame_nibbles = total_d;
    if (word_ready) begin
      res_valid_o        = 1'b1;
      res_o.packed_word  = acc_cap;
      res_o.word_nibbles = WNIB_W'(NIBBLES_PER_WORD);
      res_o.frame_done   = frame_ends;
    end else begin
      res_valid_o        = frame_ends && (acc_d != '0);
      res_o.packed_word  = acc_d;
      res_o.word_nibbles = WNIB_W'(slot_d);
      res_o.frame_done   = 1'b1;
    end

    if (frame_ends) begin
      phase_d = PH_IDLE;
      acc_d   = '0;
      slot_d  = '0;
      pif_d   = 1'b0;
    end
    prev_d = s;

    // The last sample of a capture rearms the whole frame state.
    if (capture_end_i) begin
      phase_d = PH_SEARCH;
      prev_d  = '0;
      pif_d   = 1'b0;
      acc_d   = '0;
      slot_d  = '0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      prev_q  <= '0;
      pif_q   <= 1'b0;
      acc_q   <= '0;
      slot_q  <= '0;
      total_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      pif_q   <= pif_d;
      acc_q   <= acc_d;
      slot_q  <= slot_d;
      total_q <= total_d;
    end
  end

endmodule

// ===== sv/quad_spi_sample_deserializer_top.sv =====
// A sample's word, if any, is registered in the output register when the core steps on it.
// Throughput: one sample per cycle; the input register drains into the core
// whenever the output register is empty or being taken in the same cycle.
// Reset (rst_ni low, asynchronous) clears edge mode to 0, the frame state and
// the valid flags of both pipeline registers; the block then searches for select high.
// Depends on qsd_pkg and qsd_core.
`timescale 1ns / 1ps

module quad_spi_sample_deserializer_top import qsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [MODE_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_byte_i,
  input  logic                  capture_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WORD_W-1:0]     packed_word_o,
  output logic [WNIB_W-1:0]     word_nibbles_o,
  output logic                  frame_done_o,
  output logic [COUNT_BITS-1:0] frame_nibbles_o
);

  logic [MODE_W-1:0]   mode_q;
  logic                in_valid_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                end_q;
  logic                out_valid_q;
  qsd_result_t         out_q;
  logic                step;
  logic                res_valid;
  qsd_result_t         res;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_AFTER;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      sample_q <= sample_byte_i;
      end_q    <= capture_end_i;
    end
  end

  qsd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .sample_byte_i (sample_q),
    .capture_end_i (end_q),
    .edge_mode_i   (mode_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign packed_word_o   = out_q.packed_word;
  assign word_nibbles_o  = out_q.word_nibbles;
  assign frame_done_o    = out_q.frame_done;
  assign frame_nibbles_o = out_q.frame_nibbles;

  // A word never carries zero nibbles or more than a full word.
  a_nibbles_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (word_nibbles_o != '0) &&
                    (word_nibbles_o <= WNIB_W'(NIBBLES_PER_WORD)))
    else $error("word nibble count out of range");

  // Only the word that ends a frame may be partial.
  a_partial_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_done_o) |-> (word_nibbles_o == WNIB_W'(NIBBLES_PER_WORD)))
    else $error("partial word emitted before frame end");

  // The frame count includes every nibble of the word being delivered.
  a_total_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_nibbles_o >= COUNT_BITS'(word_nibbles_o)))
    else $error("frame nibble count below word nibble count");

  // A sample waiting in the input register moves on as soon as the output is free.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |-> step)
    else $error("input register stalled with empty output");

endmodule

// ===== tb/qsd_checker.sv =====
// Scoreboard for the quad-SPI sample deserializer: predicts packed words from
// accepted samples and compares them with the words the block hands out.
// Depends on qsd_pkg.
`timescale 1ns / 1ps

module qsd_checker import qsd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [MODE_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SAMPLE_W-1:0]   sample_byte_i,
  input  logic                  capture_end_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [WORD_W-1:0]     packed_word_i,
  input  logic [WNIB_W-1:0]     word_nibbles_i,
  input  logic                  frame_done_i,
  input  logic [COUNT_BITS-1:0] frame_nibbles_i,
  output int unsigned           mismatches_o,
  output int unsigned           pending_o,
  output int unsigned           words_checked_o
);

  typedef enum logic [1:0] {SEEK_SELECT, IN_FRAME, WAIT_END} frame_phase_e;

  localparam logic [COUNT_BITS-1:0] TOTAL_MAX = '1;

  logic [MODE_W-1:0]     edge_mode;
  frame_phase_e          phase;
  logic [5:0]            last_sample;
  logic                  last_in_frame;
  logic [WORD_W-1:0]     acc;
  int unsigned           slot;
  logic [COUNT_BITS-1:0] total;
  logic                  full_word_ready;
  logic [WORD_W-1:0]     full_word;
  qsd_result_t           expected_words[$];
  qsd_result_t           oldest_word;
  int unsigned           mismatch_cnt;
  int unsigned           checked_cnt;

  function automatic void rearm_frame();
    phase         = SEEK_SELECT;
    last_sample   = '0;
    last_in_frame = 1'b0;
    acc           = '0;
    slot          = 0;
    total         = '0;
  endfunction

  function automatic void pack_nibble(input logic [5:0] s);
    logic [WORD_W-1:0] nib_ext;
    nib_ext = '0;
    nib_ext[NIB_W-1:0] = s[NIB_W-1:0];
    acc |= nib_ext << (NIB_W * slot);
    if (total != TOTAL_MAX) total++;
    slot++;
    if (slot >= NIBBLES_PER_WORD) begin
      full_word_ready = 1'b1;
      full_word       = acc;
      acc             = '0;
      slot            = 0;
    end
  endfunction

  function automatic void deserialize_sample(input logic [SAMPLE_W-1:0] raw, input logic last);
    logic [5:0]  s;
    logic        before_mode;
    logic        first_cap;
    logic        fell;
    logic        ends;
    qsd_result_t r;
    s           = raw[5:0];
    before_mode = (edge_mode != MODE_AFTER);
    // The fourth code behaves like the first-sample mode.
    first_cap   = (edge_mode >= MODE_FIRST);
    fell        = last_sample[CLK_POS] && !s[CLK_POS];
    ends        = 1'b0;
    full_word_ready = 1'b0;
    case (phase)
      SEEK_SELECT: begin
        if (s[SEL_POS]) begin
          phase = IN_FRAME;
          if (first_cap) pack_nibble(s);
          else if (!before_mode && fell) pack_nibble(s);
          last_in_frame = !first_cap;
          ends = last;
        end
      end
      IN_FRAME: begin
        // In the pre-edge modes the nibble comes from the sample before the edge.
        if (before_mode && last_in_frame && fell) pack_nibble(last_sample);
        if (s[SEL_POS]) begin
          if (!before_mode && fell) pack_nibble(s);
          last_in_frame = 1'b1;
          ends = last;
        end else begin
          ends = 1'b1;
        end
      end
      default: ;
    endcase

    if (full_word_ready) begin
      r.packed_word   = full_word;
      r.word_nibbles  = WNIB_W'(NIBBLES_PER_WORD);
      r.frame_done    = ends;
      r.frame_nibbles = total;
      expected_words.push_back(r);
    end else if (ends && acc != '0) begin
      r.packed_word   = acc;
      r.word_nibbles  = WNIB_W'(slot);
      r.frame_done    = 1'b1;
      r.frame_nibbles = total;
      expected_words.push_back(r);
    end

    if (ends) begin
      phase         = WAIT_END;
      acc           = '0;
      slot          = 0;
      last_in_frame = 1'b0;
    end
    last_sample = s;
    if (last) rearm_frame();
  endfunction

  function automatic int field_differs(input string what, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
    if (got === want) return 0;
    $error("%s: expected 0x%0h, got 0x%0h", what, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_mode = MODE_AFTER;
      rearm_frame();
      expected_words.delete();
    end else begin
      // Words leave only after their sample has been accepted, so compare first.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word 0x%0h with no prediction waiting", packed_word_i);
          mismatch_cnt++;
        end else begin
          oldest_word = expected_words.pop_front();
          mismatch_cnt += field_differs("packed_word", oldest_word.packed_word, packed_word_i);
          mismatch_cnt += field_differs("word_nibbles", WORD_W'(oldest_word.word_nibbles),
                                        WORD_W'(word_nibbles_i));
          mismatch_cnt += field_differs("frame_done", WORD_W'(oldest_word.frame_done),
                                        WORD_W'(frame_done_i));
          mismatch_cnt += field_differs("frame_nibbles", WORD_W'(oldest_word.frame_nibbles),
                                        WORD_W'(frame_nibbles_i));
          checked_cnt++;
        end
      end
      if (in_valid_i && in_ready_i) deserialize_sample(sample_byte_i, capture_end_i);
      if (cfg_valid_i && cfg_ready_i) edge_mode = cfg_data_i;
    end
    pending_o       <= expected_words.size();
    mismatches_o    <= mismatch_cnt;
    words_checked_o <= checked_cnt;
  end

endmodule

// ===== tb/quad_spi_sample_deserializer_top_tb.sv =====
// Top of the deserializer testbench: clock, reset, sample stimulus, edge-mode
// writes, output back-pressure, watchdog and verdict. Depends on qsd_pkg,
// qsd_checker and quad_spi_sample_deserializer_top.
`timescale 1ns / 1ps

module quad_spi_sample_deserializer_top_tb;
  import qsd_pkg::*;

  typedef enum logic [1:0] {END_ON_SELECT, END_ON_DROP, END_AFTER_TAIL} frame_end_e;

  localparam int RANDOM_SAMPLES = 750;
  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [MODE_W-1:0] MODE_ALIAS = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MODE_W-1:0]     cfg_data = MODE_AFTER;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   sample_byte = '0;
  logic                  capture_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [WORD_W-1:0]     packed_word;
  logic [WNIB_W-1:0]     word_nibbles;
  logic                  frame_done;
  logic [COUNT_BITS-1:0] frame_nibbles;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned samples_sent = 0;
  int unsigned captures = 0;
  int unsigned mode_writes = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_style = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_tick = 0;
  logic [MODE_W-1:0] mode_cycle [4] = '{MODE_BEFORE, MODE_FIRST, MODE_AFTER, MODE_ALIAS};

  quad_spi_sample_deserializer_top DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .sample_byte_i  (sample_byte),
    .capture_end_i  (capture_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .packed_word_o  (packed_word),
    .word_nibbles_o (word_nibbles),
    .frame_done_o   (frame_done),
    .frame_nibbles_o(frame_nibbles)
  );

  qsd_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .sample_byte_i  (sample_byte),
    .capture_end_i  (capture_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .packed_word_i  (packed_word),
    .word_nibbles_i (word_nibbles),
    .frame_done_i   (frame_done),
    .frame_nibbles_i(frame_nibbles),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .words_checked_o(words_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver switches at random intervals between always ready, random
  // stalls, sparse readiness and a fixed duty pattern.
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_style <= $urandom_range(0, 3);
      rx_hold  <= $urandom_range(8, 64);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_tick % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
               IDLE_LIMIT, pending);
      $display("quad_spi_sample_deserializer_top_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid    <= 1'b1;
    sample_byte <= b;
    capture_end <= last;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Hold off the sender until every predicted word has come out, then give
  // the pipeline time to finish any sample that produces no word.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // One capture with a proper frame: idle lead-in, a selected stretch with a
  // toggling clock and random data, then one of three ways to end it.
  task automatic send_frame_capture();
    int unsigned        nib_count;
    int unsigned        halves;
    int unsigned        reps;
    int unsigned        tail;
    logic               clk_lvl;
    logic [NIB_W-1:0]   nib;
    logic [SAMPLE_W-1:0] b;
    frame_end_e         ending;
    ending = frame_end_e'($urandom_range(0, 2));
    repeat ($urandom_range(0, 3)) begin
      b = SAMPLE_W'($urandom_range(0, 255));
      b[SEL_POS] = 1'b0;
      send_sample(b, 1'b0);
    end
    case ($urandom_range(0, 5))
      0: nib_count = $urandom_range(0, 3);
      1: nib_count = NIBBLES_PER_WORD - 1 + $urandom_range(0, 2);
      2: nib_count = 2 * NIBBLES_PER_WORD - $urandom_range(0, 1);
      default: nib_count = $urandom_range(1, 40);
    endcase
    halves  = 2 * nib_count + 1;
    clk_lvl = 1'($urandom_range(0, 1));
    for (int unsigned h = 0; h < halves; h++) begin
      reps = ($urandom_range(0, 3) == 0) ? 2 : 1;
      nib  = NIB_W'($urandom_range(0, 15));
      for (int unsigned r = 0; r < reps; r++) begin
        b = SAMPLE_W'($urandom_range(0, 255));
        b[CLK_POS] = clk_lvl ^ h[0];
        b[SEL_POS] = 1'b1;
        b[NIB_W-1:0] = nib;
        send_sample(b, (ending == END_ON_SELECT) && (h == halves - 1) && (r == reps - 1));
      end
    end
    if (ending != END_ON_SELECT) begin
      b = SAMPLE_W'($urandom_range(0, 255));
      b[SEL_POS] = 1'b0;
      send_sample(b, ending == END_ON_DROP);
      if (ending == END_AFTER_TAIL) begin
        tail = $urandom_range(1, 3);
        // Anything after the frame is ignored until the capture ends.
        for (int unsigned t = 0; t < tail; t++) begin
          send_sample(SAMPLE_W'($urandom_range(0, 255)), t == tail - 1);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default mode: short frame flushed on select drop, then ignored samples.
    send_sample(8'h00, 1'b0);
    send_sample(8'hFF, 1'b0);
    send_sample(8'hD5, 1'b0);
    send_sample(8'h3A, 1'b0);
    send_sample(8'h10, 1'b0);
    send_sample(8'h0C, 1'b0);
    send_sample(8'h3F, 1'b0);
    send_sample(8'h10, 1'b1);
    // A partial word of zero nibbles is never flushed.
    send_sample(8'h30, 1'b0);
    send_sample(8'h10, 1'b0);
    send_sample(8'h00, 1'b1);
    // A capture without select produces nothing.
    send_sample(8'hEF, 1'b0);
    send_sample(8'hCF, 1'b1);
    // Capture ending on a selected sample right after an edge.
    send_sample(8'h37, 1'b0);
    send_sample(8'h19, 1'b1);

    // The unused fourth mode code: first sample taken, then pre-edge capture.
    write_mode(MODE_ALIAS);
    send_sample(8'h3B, 1'b0);
    send_sample(8'h14, 1'b0);
    send_sample(8'h36, 1'b0);
    send_sample(8'h12, 1'b1);

    // Pre-edge mode with the capture ending on a selected sample.
    write_mode(MODE_BEFORE);
    send_sample(8'h20, 1'b0);
    send_sample(8'h3C, 1'b0);
    send_sample(8'h11, 1'b0);
    send_sample(8'h37, 1'b1);

    while (samples_sent < 23 + RANDOM_SAMPLES) begin
      if (captures % 3 == 2) write_mode(mode_cycle[mode_writes % 4]);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(0, 11)) begin
          send_sample(SAMPLE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
        send_sample(SAMPLE_W'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_frame_capture();
      end
      captures++;
    end

    wait_drained();
    $display("Run covered %0d samples in %0d captures across %0d edge-mode writes.",
             samples_sent, captures, mode_writes);
    $display("%0d words compared, %0d field mismatches.", words_checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("quad_spi_sample_deserializer_top_tb OK");
    end else begin
      $display("quad_spi_sample_deserializer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
